[design/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int PRIO_BITS    = 8;
    localparam int PAYLOAD_BITS = 16;
    localparam int COUNT_BITS   = $clog2(DEPTH + 1);

    typedef logic [PRIO_BITS-1:0]    prio_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [COUNT_BITS-1:0]   count_t;

    typedef enum logic
    {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Broadcast command to every cell of the chain.
    typedef struct packed
    {
        logic ins;
        logic rem;
    } spq_cmd_t;

endpackage

[design/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts right on insert
// below it, shifts left on remove.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic     clk,
    input  spq_cmd_t cmd,
    input  logic     occupied,
    input  prio_t    new_prio,
    input  payload_t new_payload,
    input  logic     left_keep,
    input  prio_t    left_prio,
    input  payload_t left_payload,
    input  prio_t    right_prio,
    input  payload_t right_payload,
    output logic     keep,
    output prio_t    prio,
    output payload_t payload
);

    prio_t    prio_reg;
    payload_t payload_reg;

    // Held entry stays put if it ranks at or above the newcomer (stable order).
    assign keep    = occupied && (prio_reg >= new_prio);
    assign prio    = prio_reg;
    assign payload = payload_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ins && !keep)
        begin
            if (left_keep)
            begin
                prio_reg    <= new_prio;
                payload_reg <= new_payload;
            end
            else
            begin
                prio_reg    <= left_prio;
                payload_reg <= left_payload;
            end
        end
        else if (cmd.rem)
        begin
            prio_reg    <= right_prio;
            payload_reg <= right_payload;
        end
    end

endmodule

[design/sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue built as a chain of sorted shift cells.
// ----------------------------------------------------------------------------
// Holds up to DEPTH entries in a row of cells sorted by descending priority;
// equal priorities leave in arrival order. An insert item (kind 0) drops its
// payload in behind every entry of equal or higher priority, or comes back
// with status FULL. A remove item (kind 1) returns the front entry, or status
// EMPTY with zero data. Every result carries the entry count after the
// operation. All cells compare the new priority in parallel and shift by one
// slot at the accepting edge, and the result sits in an output register, so a
// new item is taken every cycle the result side is not stalling. Slots beyond
// the fill count are never read and need no reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     kind,
    input  prio_t    prio_in,
    input  payload_t payload_in,
    output logic     out_valid,
    input  logic     out_stall,
    output status_t  status,
    output prio_t    prio_out,
    output payload_t payload_out,
    output count_t   fill_count
);

    count_t   count_reg, count_next;
    logic     out_valid_reg, out_valid_next;
    status_t  status_reg, status_next;
    prio_t    prio_out_reg, prio_out_next;
    payload_t payload_out_reg, payload_out_next;

    logic     accept;
    logic     full, empty;
    spq_cmd_t cmd;

    logic     keep_w    [DEPTH];
    prio_t    prio_w    [DEPTH];
    payload_t payload_w [DEPTH];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == count_t'(DEPTH));
    assign empty    = (count_reg == '0);

    assign cmd.ins = accept && (kind == KIND_INSERT) && !full;
    assign cmd.rem = accept && (kind == KIND_REMOVE) && !empty;

    // ---- cell chain --------------------------------------------------------
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic     lk;
            prio_t    lp;
            payload_t lpl;
            prio_t    rp;
            payload_t rpl;

            if (g == 0)
            begin : g_head
                assign lk  = 1'b1;
                assign lp  = '0;
                assign lpl = '0;
            end
            else
            begin : g_body
                assign lk  = keep_w[g-1];
                assign lp  = prio_w[g-1];
                assign lpl = payload_w[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_tail
                assign rp  = '0;
                assign rpl = '0;
            end
            else
            begin : g_mid
                assign rp  = prio_w[g+1];
                assign rpl = payload_w[g+1];
            end

            spq_cell u_cell
            (
                .clk           (clk),
                .cmd           (cmd),
                .occupied      (count_t'(g) < count_reg),
                .new_prio      (prio_in),
                .new_payload   (payload_in),
                .left_keep     (lk),
                .left_prio     (lp),
                .left_payload  (lpl),
                .right_prio    (rp),
                .right_payload (rpl),
                .keep          (keep_w[g]),
                .prio          (prio_w[g]),
                .payload       (payload_w[g])
            );
        end
    endgenerate

    // ---- control and result register ---------------------------------------
    always_comb
    begin
        count_next       = count_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        prio_out_next    = prio_out_reg;
        payload_out_next = payload_out_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (accept)
        begin
            out_valid_next   = 1'b1;
            status_next      = STATUS_OK;
            prio_out_next    = '0;
            payload_out_next = '0;
            case (kind_t'(kind))
                KIND_INSERT:
                begin
                    if (full)
                        status_next = STATUS_FULL;
                    else
                        count_next = count_reg + 1'b1;
                end
                KIND_REMOVE:
                begin
                    if (empty)
                        status_next = STATUS_EMPTY;
                    else
                    begin
                        prio_out_next    = prio_w[0];
                        payload_out_next = payload_w[0];
                        count_next       = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        prio_out_reg    <= prio_out_next;
        payload_out_reg <= payload_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign prio_out    = prio_out_reg;
    assign payload_out = payload_out_reg;
    assign fill_count  = count_reg;

    // ---- assertions --------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(DEPTH))
        else $error("entry count above depth");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_FULL |-> count_reg == count_t'(DEPTH))
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_EMPTY |-> count_reg == '0 && prio_out_reg == '0)
        else $error("empty status with entries held");

endmodule

[verif/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking testbench for the sorted priority queue.
// ----------------------------------------------------------------------------
// A local copy of the queue (slot arrays plus an entry count) is updated at
// every accepted item and yields the expected result, which waits in a FIFO
// until the block hands back a result. Results are compared field by field.
// Directed items hit the empty pop, fill to full, the rejected insert, tie
// order and the priority and payload extremes. Random traffic then runs in
// bursts of inserts or removes so the fill level swings between empty and
// full, under three idle/stall mixes: light sender gaps with heavy result
// stalls, the reverse, and none at all.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed
    {
        status_t  status;
        prio_t    prio;
        payload_t payload;
        count_t   count;
    } queue_result_t;

    logic     clk         = 1'b0;
    logic     rst_n       = 1'b0;
    logic     in_valid    = 1'b0;
    logic     in_stall;
    kind_t    op_kind     = KIND_INSERT;
    prio_t    prio_in     = '0;
    payload_t payload_in  = '0;
    logic     out_valid;
    logic     out_stall   = 1'b0;
    status_t  status;
    prio_t    prio_out;
    payload_t payload_out;
    count_t   fill_count;

    // Local copy of the queue contents, front entry in slot 0.
    prio_t    slot_prio [DEPTH];
    payload_t slot_payload [DEPTH];
    int       held_entries = 0;

    queue_result_t expected_results [$];
    queue_result_t oldest_result;
    int            mismatch_count = 0;
    int            cycle_count    = 0;

    // Idle odds in percent, changed per phase.
    int send_gap_pct     = 0;
    int result_stall_pct = 0;

    sorted_priority_queue dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (op_kind),
        .prio_in     (prio_in),
        .payload_in  (payload_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .prio_out    (prio_out),
        .payload_out (payload_out),
        .fill_count  (fill_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side stalls at random.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < result_stall_pct);
    end

    // Apply one operation to the local queue and return what it should give.
    // A new entry goes behind every entry of equal or higher priority.
    function automatic queue_result_t apply_queue_op(kind_t k, prio_t p, payload_t d);
        queue_result_t r;
        int            pos;
        int            i;
        r.status  = STATUS_OK;
        r.prio    = '0;
        r.payload = '0;
        if (k == KIND_INSERT)
        begin
            if (held_entries >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < held_entries && slot_prio[pos] >= p)
                    pos++;
                for (i = held_entries; i > pos; i--)
                begin
                    slot_prio[i]    = slot_prio[i-1];
                    slot_payload[i] = slot_payload[i-1];
                end
                slot_prio[pos]    = p;
                slot_payload[pos] = d;
                held_entries++;
            end
        end
        else
        begin
            if (held_entries == 0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                r.prio    = slot_prio[0];
                r.payload = slot_payload[0];
                for (i = 1; i < held_entries; i++)
                begin
                    slot_prio[i-1]    = slot_prio[i];
                    slot_payload[i-1] = slot_payload[i];
                end
                held_entries--;
            end
        end
        r.count = count_t'(held_entries);
        return r;
    endfunction

    // Predict on accepted items, check accepted results. Both in one process
    // so a same-edge accept and result cannot race.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(apply_queue_op(op_kind, prio_in, payload_in));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d fill_count %0d",
                           status, fill_count);
                    mismatch_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (status !== oldest_result.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               oldest_result.status, status);
                        mismatch_count++;
                    end
                    if (prio_out !== oldest_result.prio)
                    begin
                        $error("prio_out: expected %0d, actual %0d",
                               oldest_result.prio, prio_out);
                        mismatch_count++;
                    end
                    if (payload_out !== oldest_result.payload)
                    begin
                        $error("payload_out: expected %0h, actual %0h",
                               oldest_result.payload, payload_out);
                        mismatch_count++;
                    end
                    if (fill_count !== oldest_result.count)
                    begin
                        $error("fill_count: expected %0d, actual %0d",
                               oldest_result.count, fill_count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    // Send one item; returns just after the edge that took it.
    task automatic send_item(input kind_t k, input prio_t p, input payload_t d);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op_kind    <= k;
        prio_in    <= p;
        payload_in <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold off the sender until every expected result is back.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic prio_t pick_prio();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2, 3:    return prio_t'($urandom_range(3));
            default: return prio_t'($urandom);
        endcase
    endfunction

    function automatic payload_t pick_payload();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return payload_t'($urandom);
        endcase
    endfunction

    task automatic test_remove_on_empty();
        send_item(KIND_REMOVE, 8'hFF, 16'hFFFF);
    endtask

    // Mix of extremes and ties, then one insert past full.
    task automatic test_fill_to_full();
        prio_t prios [16];
        int    i;
        prios = '{8'h00, 8'hFF, 8'h80, 8'h80, 8'h80, 8'h7F, 8'h01, 8'hFF,
                  8'h00, 8'h55, 8'hAA, 8'h80, 8'hFE, 8'h00, 8'h40, 8'hFF};
        for (i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                send_item(KIND_INSERT, prios[i], 16'h0000);
            else if (i == 1)
                send_item(KIND_INSERT, prios[i], 16'hFFFF);
            else
                send_item(KIND_INSERT, prios[i], payload_t'(16'h5A00 + i));
        end
        send_item(KIND_INSERT, 8'hFF, 16'hBEEF);
        wait_until_drained();
    endtask

    // Pops the three 0xFF ties first, in arrival order.
    task automatic test_partial_drain();
        repeat (5)
            send_item(KIND_REMOVE, 8'h00, 16'h0000);
    endtask

    // Bursts of one operation with a few of the other mixed in, so the fill
    // level walks the whole range and hits both full and empty.
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input int item_total);
        int    sent;
        int    burst;
        kind_t burst_kind;
        kind_t k;
        send_gap_pct     = gap_pct;
        result_stall_pct = stall_pct;
        sent = 0;
        while (sent < item_total)
        begin
            burst_kind = $urandom_range(1) ? KIND_REMOVE : KIND_INSERT;
            burst      = $urandom_range(20, 1);
            repeat (burst)
            begin
                k = burst_kind;
                if ($urandom_range(9) == 0)
                    k = (burst_kind == KIND_INSERT) ? KIND_REMOVE : KIND_INSERT;
                send_item(k, pick_prio(), pick_payload());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct     = 14;
        result_stall_pct = 85;
        test_remove_on_empty();
        test_fill_to_full();
        test_partial_drain();

        test_random_traffic(14, 85, 310);
        test_random_traffic(85, 14, 310);
        test_random_traffic(0, 0, 310);

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
